// File: rtl/ptst_pkg.sv
`default_nettype none

package ptst_pkg;

    localparam int TIME_WIDTH  = 48;
    localparam int MAX_LOGS    = 3;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 200;
    localparam int OUT_TUSER_W = 1;

    typedef logic [TIME_WIDTH-1:0] t_time;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_CCA   = 3'd1,
        ST_RX    = 3'd2,
        ST_TX    = 3'd3,
        ST_SW    = 3'd4,
        ST_SLEEP = 3'd5,
        ST_OFF   = 3'd6
    } t_phy_state;

    typedef enum logic [3:0] {
        CMD_QUERY    = 4'd0,
        CMD_TX       = 4'd1,
        CMD_RX       = 4'd2,
        CMD_SWITCH   = 4'd3,
        CMD_CCA      = 4'd4,
        CMD_SLEEP    = 4'd5,
        CMD_WAKE     = 4'd6,
        CMD_OFF      = 4'd7,
        CMD_ON       = 4'd8,
        CMD_RX_END   = 4'd9,
        CMD_RX_ABORT = 4'd10
    } t_cmd;

    // one input beat, decoded into fields
    typedef struct packed {
        logic [3:0] command;
        t_time      now_time;
        t_time      duration;
        logic       primary_channel;
        logic [6:0] state_mask;
    } t_item;

    // one closed interval
    typedef struct packed {
        t_time      start;
        t_time      duration;
        t_phy_state state;
    } t_log;

    // everything one item produces
    typedef struct packed {
        t_log [MAX_LOGS-1:0] logs;
        logic [1:0]          log_count;
        t_phy_state          state_now;
        t_time               delay_until_idle;
        t_time               last_time;
        logic                error;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/ptst_core.sv
`default_nettype none

module ptst_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire ptst_pkg::t_item   i_item,
    output ptst_pkg::t_result      o_result
);
    import ptst_pkg::*;

    function automatic t_time time_max(input t_time a, input t_time b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_time time_subs(input t_time a, input t_time b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic t_time time_adds(input t_time a, input t_time b);
        logic [TIME_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    endfunction

    function automatic t_phy_state state_at(input logic off, input logic sleep,
                                            input t_time etx, input t_time erx,
                                            input t_time esw, input t_time ecca,
                                            input t_time now);
        t_phy_state s;
        priority if (off)        s = ST_OFF;
        else if (sleep)          s = ST_SLEEP;
        else if (etx > now)      s = ST_TX;
        else if (erx > now)      s = ST_RX;
        else if (esw > now)      s = ST_SW;
        else if (ecca > now)     s = ST_CCA;
        else                     s = ST_IDLE;
        return s;
    endfunction

    // state
    t_time r_end_tx, r_end_rx, r_end_sw, r_end_cca, r_end_sleep, r_end_off, r_end_idle;
    t_time r_start_tx, r_start_rx, r_start_cca, r_start_sleep;
    logic  r_is_sleeping, r_is_powered_off;

    t_time n_end_tx, n_end_rx, n_end_sw, n_end_cca, n_end_sleep, n_end_off, n_end_idle;
    t_time n_start_tx, n_start_rx, n_start_cca, n_start_sleep;
    logic  n_is_sleeping, n_is_powered_off;

    t_time      now, dur, sum_end, others, b_cca, istart, cs, lastt, masked_max, delay;
    t_phy_state cur_s, new_s;
    logic       err, close_do, sw_clip;
    logic       a_v, b_v, c_v, d_v;
    t_log       a_log, b_log, c_log, d_log;
    t_log [MAX_LOGS-1:0] logs;
    logic [1:0] cnt;
    t_time      ends [7];
    t_time      ends_m [7];
    t_log       cand [4];
    logic [3:0] cand_v;

    assign now     = i_item.now_time;
    assign dur     = i_item.duration;
    assign sum_end = time_adds(now, dur);
    assign cur_s   = state_at(r_is_powered_off, r_is_sleeping, r_end_tx, r_end_rx,
                              r_end_sw, r_end_cca, now);

    // start points used when idle / cca-busy gets closed
    assign others = time_max(time_max(time_max(r_end_rx, r_end_tx), r_end_sw),
                             time_max(r_end_sleep, r_end_off));
    assign b_cca  = time_max(others, r_start_cca);
    assign istart = time_max(r_end_cca, others);
    assign cs     = time_max(r_start_cca, others);

    // query: latest end among masked states, indexed by state code
    assign ends[0] = r_end_idle;
    assign ends[1] = r_end_cca;
    assign ends[2] = r_end_rx;
    assign ends[3] = r_end_tx;
    assign ends[4] = r_end_sw;
    assign ends[5] = r_end_sleep;
    assign ends[6] = r_end_off;

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            ends_m[k] = i_item.state_mask[k] ? ends[k] : '0;
        end
    end

    // balanced max tree, three levels deep
    assign masked_max = time_max(time_max(time_max(ends_m[0], ends_m[1]),
                                          time_max(ends_m[2], ends_m[3])),
                                 time_max(time_max(ends_m[4], ends_m[5]), ends_m[6]));

    always_comb begin
        n_end_tx         = r_end_tx;
        n_end_rx         = r_end_rx;
        n_end_sw         = r_end_sw;
        n_end_cca        = r_end_cca;
        n_end_sleep      = r_end_sleep;
        n_end_off        = r_end_off;
        n_end_idle       = r_end_idle;
        n_start_tx       = r_start_tx;
        n_start_rx       = r_start_rx;
        n_start_cca      = r_start_cca;
        n_start_sleep    = r_start_sleep;
        n_is_sleeping    = r_is_sleeping;
        n_is_powered_off = r_is_powered_off;
        err      = 1'b0;
        close_do = 1'b0;
        sw_clip  = 1'b0;
        c_v      = 1'b0;
        c_log    = '0;
        d_v      = 1'b0;
        d_log    = '0;
        lastt    = '0;

        unique case (t_cmd'(i_item.command))
            CMD_QUERY: begin
                lastt = i_item.state_mask[cur_s] ? now : masked_max;
            end
            CMD_TX, CMD_SWITCH: begin
                if (cur_s == ST_RX) begin
                    c_v      = 1'b1;
                    c_log    = '{r_start_rx, time_subs(now, r_start_rx), ST_RX};
                    n_end_rx = now;
                end else if (cur_s == ST_CCA || cur_s == ST_IDLE) begin
                    close_do = 1'b1;
                end else begin
                    err = 1'b1;
                end
                if (!err) begin
                    d_v = 1'b1;
                    if (t_cmd'(i_item.command) == CMD_TX) begin
                        d_log      = '{now, dur, ST_TX};
                        n_end_tx   = sum_end;
                        n_start_tx = now;
                    end else begin
                        d_log    = '{now, dur, ST_SW};
                        n_end_sw = sum_end;
                        sw_clip  = 1'b1;
                    end
                end
            end
            CMD_RX: begin
                if (cur_s == ST_CCA || cur_s == ST_IDLE) begin
                    close_do   = 1'b1;
                    n_start_rx = now;
                    n_end_rx   = sum_end;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_CCA: begin
                // ignored in rx or for a secondary channel, never an error
                if (cur_s != ST_RX && i_item.primary_channel) begin
                    close_do = (cur_s == ST_IDLE);
                    if (cur_s != ST_CCA) n_start_cca = now;
                    n_end_cca = time_max(r_end_cca, sum_end);
                end
            end
            CMD_SLEEP: begin
                if (cur_s == ST_CCA || cur_s == ST_IDLE) begin
                    close_do      = 1'b1;
                    n_is_sleeping = 1'b1;
                    n_start_sleep = now;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_WAKE: begin
                if (cur_s == ST_SLEEP) begin
                    c_v           = 1'b1;
                    c_log         = '{r_start_sleep, time_subs(now, r_start_sleep), ST_SLEEP};
                    n_is_sleeping = 1'b0;
                    n_end_sleep   = now;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_OFF: begin
                if (cur_s == ST_RX) begin
                    c_v      = 1'b1;
                    c_log    = '{r_start_rx, time_subs(now, r_start_rx), ST_RX};
                    n_end_rx = now;
                end else if (cur_s == ST_TX) begin
                    c_v      = 1'b1;
                    c_log    = '{r_start_tx, time_subs(now, r_start_tx), ST_TX};
                    n_end_tx = now;
                end else if (cur_s == ST_CCA || cur_s == ST_IDLE) begin
                    close_do = 1'b1;
                end else begin
                    err = 1'b1;
                end
                if (!err) n_is_powered_off = 1'b1;
            end
            CMD_ON: begin
                if (cur_s == ST_OFF) begin
                    n_is_powered_off = 1'b0;
                    n_end_off        = now;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_RX_END: begin
                if ((cur_s == ST_CCA || cur_s == ST_IDLE) && r_end_rx == now) begin
                    c_v      = 1'b1;
                    c_log    = '{r_start_rx, time_subs(now, r_start_rx), ST_RX};
                    n_end_rx = now;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_RX_ABORT: begin
                if (cur_s == ST_CCA) begin
                    c_v       = 1'b1;
                    c_log     = '{r_start_rx, time_subs(now, r_start_rx), ST_RX};
                    n_end_rx  = now;
                    n_end_cca = now;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        // closing idle / cca-busy
        if (close_do) begin
            if (cur_s == ST_CCA) n_end_cca = now;
            else                 n_end_idle = now;
        end
        if (sw_clip && n_end_cca > now) n_end_cca = now;
    end

    // closing logs: cca-busy first, then idle
    assign a_v = close_do && (cur_s == ST_CCA ||
                 (cur_s == ST_IDLE && r_end_cca > others && istart > cs));
    assign a_log.start    = (cur_s == ST_CCA) ? b_cca : cs;
    assign a_log.duration = (cur_s == ST_CCA) ? time_subs(now, b_cca) : time_subs(istart, cs);
    assign a_log.state    = ST_CCA;
    assign b_v   = close_do && cur_s == ST_IDLE && now > istart;
    assign b_log = '{istart, time_subs(now, istart), ST_IDLE};

    assign cand_v  = {d_v, c_v, b_v, a_v};
    assign cand[0] = a_log;
    assign cand[1] = b_log;
    assign cand[2] = c_log;
    assign cand[3] = d_log;

    // pack valid logs into the lowest slots, in order
    always_comb begin
        logs = '0;
        cnt  = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k]) begin
                logs[cnt] = cand[k];
                cnt       = cnt + 2'd1;
            end
        end
    end

    assign new_s = state_at(n_is_powered_off, n_is_sleeping, n_end_tx, n_end_rx,
                            n_end_sw, n_end_cca, now);

    always_comb begin
        unique case (new_s)
            ST_RX:   delay = time_subs(n_end_rx, now);
            ST_TX:   delay = time_subs(n_end_tx, now);
            ST_CCA:  delay = time_subs(n_end_cca, now);
            ST_SW:   delay = time_subs(n_end_sw, now);
            default: delay = '0;
        endcase
    end

    assign o_result.logs             = logs;
    assign o_result.log_count        = cnt;
    assign o_result.state_now        = new_s;
    assign o_result.delay_until_idle = delay;
    assign o_result.last_time        = lastt;
    assign o_result.error            = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_tx         <= '0;
            r_end_rx         <= '0;
            r_end_sw         <= '0;
            r_end_cca        <= '0;
            r_end_sleep      <= '0;
            r_end_off        <= '0;
            r_end_idle       <= '0;
            r_start_tx       <= '0;
            r_start_rx       <= '0;
            r_start_cca      <= '0;
            r_start_sleep    <= '0;
            r_is_sleeping    <= 1'b0;
            r_is_powered_off <= 1'b0;
        end else if (i_take) begin
            r_end_tx         <= n_end_tx;
            r_end_rx         <= n_end_rx;
            r_end_sw         <= n_end_sw;
            r_end_cca        <= n_end_cca;
            r_end_sleep      <= n_end_sleep;
            r_end_off        <= n_end_off;
            r_end_idle       <= n_end_idle;
            r_start_tx       <= n_start_tx;
            r_start_rx       <= n_start_rx;
            r_start_cca      <= n_start_cca;
            r_start_sleep    <= n_start_sleep;
            r_is_sleeping    <= n_is_sleeping;
            r_is_powered_off <= n_is_powered_off;
        end
    end

    // sleep needs idle/cca-busy, off never starts from sleep
    a_not_sleep_and_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_is_sleeping && r_is_powered_off))
        else $error("sleep and off flags both set");

    a_error_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_result.error |=>
        $stable({r_end_tx, r_end_rx, r_end_sw, r_end_cca, r_end_idle,
                 r_start_cca, r_is_sleeping, r_is_powered_off}))
        else $error("rejected command changed state");

    a_error_no_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.error |-> o_result.log_count == 2'd0)
        else $error("rejected command produced a log");

endmodule

`default_nettype wire

// File: rtl/phy_timed_state_tracker.sv
`default_nettype none

// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: command, now_time, duration,
//                                              primary_channel, state_mask
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: log and status fields,
//                                              tuser: log_valid, tlast: last
//
// One command beat per cycle when each command yields one result beat and the result
// port is not stalled; a command that closes n intervals holds the single result port
// for n beats (n up to 3). An input beat goes into the input register, then through
// the tracker into the result register. Reset (synchronous, active low) zeroes all
// times and flags and empties both registers. A stalled result port backs up into the
// input register, then s_axis.

module phy_timed_state_tracker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [3:0] command, [51:4] now_time, [99:52] duration, [100] primary_channel,
    // [107:101] state_mask, [111:108] zero
    input  wire logic [ptst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [47:0] log_start, [95:48] log_duration, [98:96] log_state, [101:99] state_now,
    // [149:102] delay_until_idle, [197:150] last_time, [198] error, [199] zero
    output logic [ptst_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] log_valid
    output logic [ptst_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import ptst_pkg::*;

    // input register
    logic    r_in_valid;
    t_item   r_in;
    t_item   in_item;

    // result register, sent out one beat per log, or a single beat when there is none
    logic    r_out_valid;
    t_result r_out;
    logic [1:0] r_out_idx;

    t_result core_result;
    t_log    sel_log;
    logic    in_fire, out_fire, out_last, out_can_load, take, log_valid;
    logic [1:0] beats;

    assign in_item.command         = s_axis_tdata[3:0];
    assign in_item.now_time        = s_axis_tdata[51:4];
    assign in_item.duration        = s_axis_tdata[99:52];
    assign in_item.primary_channel = s_axis_tdata[100];
    assign in_item.state_mask      = s_axis_tdata[107:101];

    assign beats        = (r_out.log_count == 2'd0) ? 2'd1 : r_out.log_count;
    assign out_last     = (r_out_idx == beats - 2'd1);
    assign out_fire     = m_axis_tvalid && m_axis_tready;
    assign out_can_load = !r_out_valid || (out_fire && out_last);
    assign take         = r_in_valid && out_can_load;
    assign s_axis_tready = !r_in_valid || take;
    assign in_fire      = s_axis_tvalid && s_axis_tready;

    ptst_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_idx   <= 2'd0;
        end else begin
            if (in_fire)   r_in_valid <= 1'b1;
            else if (take) r_in_valid <= 1'b0;

            if (take) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= 2'd0;
            end else if (out_fire) begin
                if (out_last) r_out_valid <= 1'b0;
                else          r_out_idx   <= r_out_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_in  <= in_item;
        if (take)    r_out <= core_result;
    end

    // log slot for this beat; blank once past the logged ones
    assign log_valid = (r_out_idx < r_out.log_count);
    assign sel_log   = log_valid ? r_out.logs[r_out_idx] : '0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tuser  = log_valid;
    assign m_axis_tdata  = {1'b0, r_out.error, r_out.last_time, r_out.delay_until_idle,
                            r_out.state_now, sel_log.state, sel_log.duration,
                            sel_log.start};

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_idx < beats)
        else $error("result beat index past end of item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !(out_fire && out_last) |-> !take)
        else $error("new item loaded over unfinished results");

    a_error_no_log_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.error |-> !m_axis_tuser[0] && m_axis_tlast)
        else $error("rejected command emitted a log beat");

endmodule

`default_nettype wire
